// File: rtl/scl_pkg.sv
`timescale 1ns / 1ps

package scl_pkg;

  localparam int VAL_W   = 40;
  localparam int DIV_W   = 43;
  localparam int BIT_W   = 6;
  localparam logic [BIT_W-1:0] DIV_MSB = 6'd42;

  localparam logic [3:0] SEL_TEMP_X     = 4'd2;
  localparam logic [3:0] SEL_LIN_Y      = 4'd5;
  localparam logic [3:0] SEL_DB_LOW     = 4'd6;
  localparam logic [3:0] SEL_DB_VALUE   = 4'd8;
  localparam logic [3:0] SEL_SWITCHES   = 4'd9;

  localparam logic ACT_WRITE = 1'b0;

  localparam logic [1:0] STAGE_CAL  = 2'd0;
  localparam logic [1:0] STAGE_TEMP = 2'd1;
  localparam logic [1:0] STAGE_LIN  = 2'd2;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE, S_X0, S_C0, S_CN, S_MID, S_MC, S_RL, S_RH, S_YL, S_YH, S_DY,
    S_D1, S_D2, S_FIN, S_Y, S_NXT, S_DBL, S_DBH, S_DBV, S_DBW, S_DONE
  } scl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_WRITE, OP_START, OP_XL, OP_DX, OP_YL, OP_DY, OP_DIV1, OP_DIV2,
    OP_FIN, OP_TAKE, OP_X0_TEMP, OP_X0_RES, OP_DBLO, OP_DBVAL, OP_OUT
  } scl_op_t;

  typedef struct packed {
    logic ch_ok;
    logic x_le;
    logic x_ge;
    logic x_eq;
    logic x_gt;
    logic db_hit;
    logic [2:0] sw;
    logic out_free;
    logic mbit;
  } scl_status_t;

endpackage

// File: rtl/scl_ctrl.sv
`timescale 1ns / 1ps

module scl_ctrl import scl_pkg::*; #(
  parameter int TABLE_POINTS    = 10,
  parameter int DEADBAND_RANGES = 5,
  parameter int OFF_W           = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  scl_status_t       status,
  output scl_op_t           op,
  output logic [1:0]        stage,
  output logic [OFF_W-1:0]  rd_off,
  output logic [BIT_W-1:0]  bit_sel
);

  localparam int IW = $clog2(TABLE_POINTS);
  localparam int DW = (DEADBAND_RANGES > 1) ? $clog2(DEADBAND_RANGES) : 1;
  localparam logic [IW-1:0] LAST_PT = IW'(TABLE_POINTS - 1);
  localparam logic [DW-1:0] LAST_DB = DW'(DEADBAND_RANGES - 1);

  scl_state_t state_r, state_nxt;
  logic [1:0]       stage_r, stage_nxt;
  logic [IW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [DW-1:0]    j_r, j_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic [IW-1:0]    lo_t, hi_t, span_t;

  function automatic logic [OFF_W-1:0] tab_off(input logic [1:0] stg, input logic ysel,
                                               input logic [IW-1:0] idx);
    tab_off = OFF_W'(32'(stg) * (2 * TABLE_POINTS) + 32'(ysel) * TABLE_POINTS + 32'(idx));
  endfunction

  function automatic logic [OFF_W-1:0] db_off(input int k, input logic [DW-1:0] idx);
    db_off = OFF_W'(6 * TABLE_POINTS + k * DEADBAND_RANGES + 32'(idx));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stage_r <= STAGE_CAL;
      lo_r    <= '0;
      hi_r    <= '0;
      mid_r   <= '0;
      j_r     <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      mid_r   <= mid_nxt;
      j_r     <= j_nxt;
      bit_r   <= bit_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    stage_nxt = stage_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    j_nxt     = j_r;
    bit_nxt   = bit_r;
    op        = OP_NONE;
    rd_off    = '0;
    in_ready  = 1'b0;
    lo_t      = lo_r;
    hi_t      = hi_r;
    span_t    = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_WRITE) begin
            op = OP_WRITE;
          end else begin
            op        = OP_START;
            stage_nxt = STAGE_CAL;
            state_nxt = status.ch_ok ? S_X0 : S_DONE;
          end
        end
      end
      S_X0: begin
        rd_off    = tab_off(stage_r, 1'b0, '0);
        state_nxt = S_C0;
      end
      S_C0: begin
        if (status.x_le) begin
          rd_off    = tab_off(stage_r, 1'b1, '0);
          state_nxt = S_Y;
        end else begin
          rd_off    = tab_off(stage_r, 1'b0, LAST_PT);
          state_nxt = S_CN;
        end
      end
      S_CN: begin
        if (status.x_ge) begin
          rd_off    = tab_off(stage_r, 1'b1, LAST_PT);
          state_nxt = S_Y;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = LAST_PT;
          state_nxt = (TABLE_POINTS > 2) ? S_MID : S_RL;
        end
      end
      S_MID: begin
        span_t    = hi_r - lo_r;
        mid_nxt   = lo_r + (span_t >> 1);
        rd_off    = tab_off(stage_r, 1'b0, mid_nxt);
        state_nxt = S_MC;
      end
      S_MC: begin
        if (status.x_eq) begin
          rd_off    = tab_off(stage_r, 1'b1, mid_r);
          state_nxt = S_Y;
        end else begin
          if (status.x_gt) begin
            lo_t = mid_r;
          end else begin
            hi_t = mid_r;
          end
          lo_nxt    = lo_t;
          hi_nxt    = hi_t;
          span_t    = hi_t - lo_t;
          state_nxt = (span_t > IW'(1)) ? S_MID : S_RL;
        end
      end
      S_RL: begin
        rd_off    = tab_off(stage_r, 1'b0, lo_r);
        state_nxt = S_RH;
      end
      S_RH: begin
        op        = OP_XL;
        rd_off    = tab_off(stage_r, 1'b0, hi_r);
        state_nxt = S_YL;
      end
      S_YL: begin
        op        = OP_DX;
        rd_off    = tab_off(stage_r, 1'b1, lo_r);
        state_nxt = S_YH;
      end
      S_YH: begin
        op        = OP_YL;
        rd_off    = tab_off(stage_r, 1'b1, hi_r);
        state_nxt = S_DY;
      end
      S_DY: begin
        op        = OP_DY;
        bit_nxt   = DIV_MSB;
        state_nxt = S_D1;
      end
      S_D1: begin
        op        = OP_DIV1;
        state_nxt = S_D2;
      end
      S_D2: begin
        op = OP_DIV2;
        if (bit_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          bit_nxt   = bit_r - BIT_W'(1);
          state_nxt = S_D1;
        end
      end
      S_FIN: begin
        op        = OP_FIN;
        state_nxt = S_NXT;
      end
      S_Y: begin
        op        = OP_TAKE;
        state_nxt = S_NXT;
      end
      S_NXT: begin
        j_nxt = '0;
        if (stage_r == STAGE_CAL && status.sw[0]) begin
          op        = OP_X0_TEMP;
          stage_nxt = STAGE_TEMP;
          state_nxt = S_X0;
        end else if (stage_r != STAGE_LIN && status.sw[1]) begin
          op        = OP_X0_RES;
          stage_nxt = STAGE_LIN;
          state_nxt = S_X0;
        end else if (status.sw[2]) begin
          state_nxt = S_DBL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DBL: begin
        rd_off    = db_off(0, j_r);
        state_nxt = S_DBH;
      end
      S_DBH: begin
        op        = OP_DBLO;
        rd_off    = db_off(1, j_r);
        state_nxt = S_DBV;
      end
      S_DBV: begin
        if (status.db_hit) begin
          rd_off    = db_off(2, j_r);
          state_nxt = S_DBW;
        end else if (j_r == LAST_DB) begin
          state_nxt = S_DONE;
        end else begin
          j_nxt     = j_r + DW'(1);
          state_nxt = S_DBL;
        end
      end
      S_DBW: begin
        op        = OP_DBVAL;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          op        = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign stage   = stage_r;
  assign bit_sel = bit_r;

endmodule

// File: rtl/scl_datapath.sv
`timescale 1ns / 1ps

module scl_datapath import scl_pkg::*; #(
  parameter int CHANNELS        = 4,
  parameter int TABLE_POINTS    = 10,
  parameter int DEADBAND_RANGES = 5,
  parameter int OFF_W           = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [1:0]              in_channel,
  input  logic [3:0]              in_table_select,
  input  logic [3:0]              in_entry_index,
  input  logic signed [VAL_W-1:0] in_entry_value,
  input  logic [15:0]             in_raw_sample,
  input  logic signed [VAL_W-1:0] in_temperature,
  input  scl_op_t                 op,
  input  logic [1:0]              stage,
  input  logic [OFF_W-1:0]        rd_off,
  input  logic [BIT_W-1:0]        bit_sel,
  output scl_status_t             status,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_reading,
  output logic [1:0]              out_channel
);

  localparam int PER   = 6 * TABLE_POINTS + 3 * DEADBAND_RANGES;
  localparam int DEPTH = CHANNELS * PER;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_r;
  logic [2:0]       sw_r [CHANNELS];

  logic [1:0]       ch_r;
  logic [VAL_W-1:0] x0_r, temp_r, res_r, xl_r, yl_r, out_reading_r;
  logic [2:0]       sw_cur_r;
  logic [DIV_W-1:0] dx_r, da_r, m_r, q_r, rem_r;
  logic             neg_r, db_lo_r, out_valid_r;
  logic [1:0]       out_channel_r;

  logic             ch_ok, wr_en;
  logic [CW-1:0]    ch_idx;
  logic [OFF_W-1:0] wr_off;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [DIV_W-1:0] rd_ext, xl_ext, yl_ext, x0_ext, dy, sh, sh_sub, ad, ad_sub, val_w;
  logic [VAL_W-1:0] val, merged;
  logic [VAL_W:0]   sum;

  assign ch_ok  = 32'(in_channel) < CHANNELS;
  assign ch_idx = CW'(in_channel);

  always_comb begin
    wr_en  = 1'b0;
    wr_off = '0;
    if (op == OP_WRITE && ch_ok) begin
      if (in_table_select <= SEL_LIN_Y) begin
        wr_en  = 32'(in_entry_index) < TABLE_POINTS;
        wr_off = OFF_W'(32'(in_table_select) * TABLE_POINTS + 32'(in_entry_index));
      end else if (in_table_select <= SEL_DB_VALUE) begin
        wr_en  = 32'(in_entry_index) < DEADBAND_RANGES;
        wr_off = OFF_W'(6 * TABLE_POINTS + 32'(in_table_select - SEL_DB_LOW) * DEADBAND_RANGES
                        + 32'(in_entry_index));
      end
    end
  end

  assign wr_addr = AW'(32'(in_channel) * PER + 32'(wr_off));
  assign rd_addr = AW'(32'(ch_r) * PER + 32'(rd_off));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_entry_value;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sw_r[i] <= '0;
      end
    end else if (op == OP_WRITE && ch_ok && in_table_select == SEL_SWITCHES) begin
      sw_r[ch_idx] <= in_entry_value[2:0];
    end
  end

  assign rd_ext = {{(DIV_W-VAL_W){rd_r[VAL_W-1]}}, rd_r};
  assign xl_ext = {{(DIV_W-VAL_W){xl_r[VAL_W-1]}}, xl_r};
  assign yl_ext = {{(DIV_W-VAL_W){yl_r[VAL_W-1]}}, yl_r};
  assign x0_ext = {{(DIV_W-VAL_W){x0_r[VAL_W-1]}}, x0_r};
  assign dy     = rd_ext - yl_ext;

  assign sh     = {rem_r[DIV_W-2:0], 1'b0};
  assign sh_sub = sh - dx_r;
  assign ad     = rem_r + da_r;
  assign ad_sub = ad - dx_r;

  assign val_w  = neg_r ? (yl_ext - q_r) : (yl_ext + q_r);

  always_comb begin
    val = (op == OP_TAKE) ? rd_r : val_w[VAL_W-1:0];
    sum = {val[VAL_W-1], val} + {res_r[VAL_W-1], res_r};
    if (stage == STAGE_CAL) begin
      merged = val;
    end else if (sum[VAL_W] != sum[VAL_W-1]) begin
      merged = sum[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      merged = sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_START: begin
        ch_r     <= in_channel;
        x0_r     <= {{(VAL_W-32){1'b0}}, in_raw_sample, 16'd0};
        temp_r   <= in_temperature;
        res_r    <= '0;
        sw_cur_r <= ch_ok ? sw_r[ch_idx] : 3'd0;
      end
      OP_XL: xl_r <= rd_r;
      OP_DX: begin
        dx_r <= rd_ext - xl_ext;
        da_r <= x0_ext - xl_ext;
      end
      OP_YL: yl_r <= rd_r;
      OP_DY: begin
        neg_r <= dy[DIV_W-1];
        m_r   <= dy[DIV_W-1] ? (~dy + DIV_W'(1)) : dy;
        q_r   <= '0;
        rem_r <= '0;
      end
      OP_DIV1: begin
        if (sh >= dx_r) begin
          rem_r <= sh_sub;
          q_r   <= {q_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_r <= sh;
          q_r   <= {q_r[DIV_W-2:0], 1'b0};
        end
      end
      OP_DIV2: begin
        if (m_r[bit_sel]) begin
          if (ad >= dx_r) begin
            rem_r <= ad_sub;
            q_r   <= q_r + DIV_W'(1);
          end else begin
            rem_r <= ad;
          end
        end
      end
      OP_FIN, OP_TAKE: res_r <= merged;
      OP_X0_TEMP:      x0_r  <= temp_r;
      OP_X0_RES:       x0_r  <= res_r;
      OP_DBLO:         db_lo_r <= $signed(res_r) >= $signed(rd_r);
      OP_DBVAL:        res_r <= rd_r;
      OP_OUT: begin
        out_reading_r <= res_r;
        out_channel_r <= ch_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    status.ch_ok    = ch_ok;
    status.x_le     = $signed(x0_r) <= $signed(rd_r);
    status.x_ge     = $signed(x0_r) >= $signed(rd_r);
    status.x_eq     = x0_r == rd_r;
    status.x_gt     = $signed(rd_r) < $signed(x0_r);
    status.db_hit   = db_lo_r && ($signed(res_r) <= $signed(rd_r));
    status.sw       = sw_cur_r;
    status.out_free = !out_valid_r || out_ready;
    status.mbit     = m_r[bit_sel];
  end

  assign out_valid   = out_valid_r;
  assign out_reading = out_reading_r;
  assign out_channel = out_channel_r;

endmodule

// File: rtl/sensor_calibration_linearizer.sv
`timescale 1ns / 1ps

// Sensor calibration linearizer, one shared engine for all channels.
// Input channel (in_valid/in_ready): in_action 0 writes one calibration word
// (table point, deadband word or switch bits) and gives no result; 1 converts
// in_raw_sample of in_channel. Result channel (out_valid/out_ready) carries
// out_reading in signed Q23.16 and out_channel.
// A write is stored when it is accepted. A conversion runs through a shared
// search and restoring divider for each interpolation (43 quotient bits, each
// a shift-subtract step and then a conditional add step), then checks the
// deadband ranges in turn; how long a result takes to be registered after
// acceptance depends on the switches. The store has a single read port. One
// item is in work at a time.
// Results sit in an output register; in_ready returns as soon as a result is
// registered, so the next transaction is taken while out_ready is low. A
// finished conversion waits only if the output register is still full.
// Reset (rst_n low, synchronous) clears the control state, the output valid
// and the channel switches; calibration tables hold nothing until written.

module sensor_calibration_linearizer import scl_pkg::*; #(
  parameter int CHANNELS        = 4,
  parameter int TABLE_POINTS    = 10,
  parameter int DEADBAND_RANGES = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_action,
  input  logic [1:0]              in_channel,
  input  logic [3:0]              in_table_select,
  input  logic [3:0]              in_entry_index,
  input  logic signed [VAL_W-1:0] in_entry_value,
  input  logic [15:0]             in_raw_sample,
  input  logic signed [VAL_W-1:0] in_temperature,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_reading,
  output logic [1:0]              out_channel
);

  localparam int PER   = 6 * TABLE_POINTS + 3 * DEADBAND_RANGES;
  localparam int OFF_W = $clog2(PER);

  scl_status_t      status;
  scl_op_t          op;
  logic [1:0]       stage;
  logic [OFF_W-1:0] rd_off;
  logic [BIT_W-1:0] bit_sel;

  scl_ctrl #(
    .TABLE_POINTS    (TABLE_POINTS),
    .DEADBAND_RANGES (DEADBAND_RANGES),
    .OFF_W           (OFF_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .status    (status),
    .op        (op),
    .stage     (stage),
    .rd_off    (rd_off),
    .bit_sel   (bit_sel)
  );

  scl_datapath #(
    .CHANNELS        (CHANNELS),
    .TABLE_POINTS    (TABLE_POINTS),
    .DEADBAND_RANGES (DEADBAND_RANGES),
    .OFF_W           (OFF_W)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_channel      (in_channel),
    .in_table_select (in_table_select),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .in_raw_sample   (in_raw_sample),
    .in_temperature  (in_temperature),
    .op              (op),
    .stage           (stage),
    .rd_off          (rd_off),
    .bit_sel         (bit_sel),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_reading     (out_reading),
    .out_channel     (out_channel)
  );

endmodule

// File: tb/sensor_calibration_linearizer_tb.sv
`timescale 1ns / 1ps

module sensor_calibration_linearizer_tb import scl_pkg::*;;

  localparam int NCH = 4;
  localparam int NPT = 10;
  localparam int NDB = 5;
  localparam longint MAXV = 64'sd549755813887;
  localparam longint MINV = -64'sd549755813888;
  localparam logic [3:0] SEL_CAL_X = 4'd0;
  localparam logic [3:0] SEL_CAL_Y = 4'd1;
  localparam logic [3:0] SEL_TEMP_Y = 4'd3;
  localparam logic [3:0] SEL_LIN_X = 4'd4;
  localparam logic [3:0] SEL_DB_HIGH = 4'd7;
  localparam logic [3:0] SEL_UNUSED = 4'd15;
  localparam logic ACT_CONVERT = 1'b1;

  typedef struct {
    logic                    action;
    logic [1:0]              channel;
    logic [3:0]              sel;
    logic [3:0]              idx;
    logic signed [VAL_W-1:0] value;
    logic [15:0]             raw;
    logic signed [VAL_W-1:0] temp;
  } txn_t;

  typedef struct {
    logic signed [VAL_W-1:0] reading;
    logic [1:0]              channel;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid;
  logic signed [VAL_W-1:0] out_reading;
  logic [1:0] out_channel;

  txn_t cur = '{default: '0};
  txn_t pending_q[$];
  reading_t readings_q[$];
  bit taken;
  int send_idle = 22;
  int recv_idle = 86;
  bit hold_go, hold_done;
  int hold_cnt;
  int errors, n_checked, n_writes, n_ignored;

  longint tbl[NCH][6][NPT];
  longint dbw[NCH][3][NDB];
  logic [2:0] sws[NCH];

  sensor_calibration_linearizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(cur.action), .in_channel(cur.channel),
    .in_table_select(cur.sel), .in_entry_index(cur.idx),
    .in_entry_value(cur.value), .in_raw_sample(cur.raw),
    .in_temperature(cur.temp),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_reading(out_reading), .out_channel(out_channel)
  );

  always #4 clk = ~clk;

  function automatic longint sat(longint v);
    if (v > MAXV) return MAXV;
    if (v < MINV) return MINV;
    return v;
  endfunction

  function automatic longint piecewise(int ch, int t, longint x0);
    int lo, hi, mid;
    longint dy, dx, da;
    logic [127:0] q;
    lo = 0;
    hi = NPT - 1;
    if (x0 <= tbl[ch][2*t][0]) return tbl[ch][2*t+1][0];
    if (x0 >= tbl[ch][2*t][NPT-1]) return tbl[ch][2*t+1][NPT-1];
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (tbl[ch][2*t][mid] == x0) return tbl[ch][2*t+1][mid];
      if (tbl[ch][2*t][mid] < x0) lo = mid;
      else hi = mid;
    end
    dy = tbl[ch][2*t+1][hi] - tbl[ch][2*t+1][lo];
    dx = tbl[ch][2*t][hi] - tbl[ch][2*t][lo];
    da = x0 - tbl[ch][2*t][lo];
    q = (128'(dy < 0 ? -dy : dy) * 128'(da)) / 128'(dx);
    return dy < 0 ? tbl[ch][2*t+1][lo] - longint'(q) : tbl[ch][2*t+1][lo] + longint'(q);
  endfunction

  task automatic absorb(input txn_t it);
    longint r;
    int ch;
    reading_t e;
    ch = int'(it.channel);
    if (it.action == ACT_WRITE) begin
      if (it.sel <= SEL_LIN_Y && it.idx < NPT) tbl[ch][it.sel][it.idx] = it.value;
      else if (it.sel >= SEL_DB_LOW && it.sel <= SEL_DB_VALUE && it.idx < NDB)
        dbw[ch][it.sel - SEL_DB_LOW][it.idx] = it.value;
      else if (it.sel == SEL_SWITCHES) sws[ch] = it.value[2:0];
      return;
    end
    r = piecewise(ch, 0, longint'({it.raw, 16'h0000}));
    if (sws[ch][0]) r = sat(r + piecewise(ch, 1, it.temp));
    if (sws[ch][1]) r = sat(r + piecewise(ch, 2, r));
    if (sws[ch][2]) begin
      for (int j = 0; j < NDB; j++) begin
        if (r >= dbw[ch][0][j] && r <= dbw[ch][1][j]) begin
          r = dbw[ch][2][j];
          break;
        end
      end
    end
    e.reading = r[VAL_W-1:0];
    e.channel = it.channel;
    readings_q.push_back(e);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || taken)) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        cur = pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    taken = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_cnt++;
      if (hold_cnt >= 400) hold_done = 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      taken = 1'b1;
      absorb(cur);
    end
    if (rst_n && out_valid && out_ready) begin
      if (readings_q.size() == 0) begin
        $error("unexpected reading %0d on channel %0d", out_reading, out_channel);
        errors++;
      end else begin
        reading_t e;
        e = readings_q.pop_front();
        n_checked++;
        if (out_reading !== e.reading) begin
          $error("reading: expected %0d, got %0d", e.reading, out_reading);
          errors++;
        end
        if (out_channel !== e.channel) begin
          $error("out_channel: expected %0d, got %0d", e.channel, out_channel);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [VAL_W-1:0] rnd40();
    return VAL_W'({$urandom(), $urandom()});
  endfunction

  function automatic longint rnd_y();
    case ($urandom_range(9))
      0: return MAXV - $urandom_range(3);
      1: return MINV + $urandom_range(3);
      2: return longint'(rnd40());
      default: return longint'($urandom_range(32'h7FFFFFFF)) - 64'sd1073741824;
    endcase
  endfunction

  task automatic put_write(int ch, logic [3:0] sel, logic [3:0] idx, longint v);
    txn_t it;
    it.action = ACT_WRITE;
    it.channel = 2'(ch);
    it.sel = sel;
    it.idx = idx;
    it.value = v[VAL_W-1:0];
    it.raw = 16'($urandom());
    it.temp = rnd40();
    pending_q.push_back(it);
    if ((sel <= SEL_LIN_Y && idx < NPT) || (sel >= SEL_DB_LOW && sel <= SEL_DB_VALUE
        && idx < NDB) || sel == SEL_SWITCHES) n_writes++;
    else n_ignored++;
  endtask

  task automatic put_conv(int ch, logic [15:0] raw, longint t);
    txn_t it;
    it.action = ACT_CONVERT;
    it.channel = 2'(ch);
    it.sel = 4'($urandom());
    it.idx = 4'($urandom());
    it.value = rnd40();
    it.raw = raw;
    it.temp = t[VAL_W-1:0];
    pending_q.push_back(it);
  endtask

  // x points must rise strictly
  task automatic put_axis(int ch, logic [3:0] sel, longint base, int unsigned step);
    longint x;
    x = base;
    for (int i = 0; i < NPT; i++) begin
      put_write(ch, sel, 4'(i), x);
      x += 1 + $urandom_range(step);
    end
  endtask

  task automatic put_random_axis(int ch, logic [3:0] sel);
    case ($urandom_range(2))
      0: put_axis(ch, sel, $urandom_range(32'h0FFFFFFF), 32'h18000000);
      1: put_axis(ch, sel, -64'sd2147483648 - $urandom_range(32'h3FFFFFFF), 32'h1FFFFFFF);
      default: put_axis(ch, sel, MINV + $urandom_range(255), 32'hFFFFFFFF);
    endcase
  endtask

  task automatic settle();
    wait (pending_q.size() == 0 && !in_valid && readings_q.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_run(int n);
    int added;
    int ch;
    longint lo;
    added = 0;
    while (added < n) begin
      ch = $urandom_range(NCH - 1);
      case ($urandom_range(99)) inside
        [0:54]: begin
          put_conv(ch, 16'($urandom()), $urandom_range(3) == 0 ? longint'(rnd40())
                   : longint'($urandom_range(32'h7FFFFFFF)) - 64'sd1073741824);
          added++;
        end
        [55:66]: begin
          put_write(ch, $urandom_range(1) ? SEL_CAL_Y
                    : 4'($urandom_range(SEL_TEMP_Y, SEL_LIN_Y)) | 4'd1,
                    4'($urandom_range(NPT - 1)), rnd_y());
          added++;
        end
        [67:76]: begin
          lo = rnd_y();
          put_write(ch, SEL_DB_LOW, 4'($urandom_range(NDB - 1)), lo);
          put_write(ch, SEL_DB_HIGH, 4'($urandom_range(NDB - 1)),
                    sat(lo + $urandom_range(32'h3FFFFFF)));
          put_write(ch, SEL_DB_VALUE, 4'($urandom_range(NDB - 1)), longint'(rnd40()));
          added += 3;
        end
        [77:84]: begin
          put_write(ch, SEL_SWITCHES, 4'($urandom()), longint'(rnd40()));
          added++;
        end
        [85:92]: begin
          put_random_axis(ch, 4'(2 * $urandom_range(2)));
          added += NPT;
        end
        default: begin
          if ($urandom_range(1))
            put_write(ch, 4'($urandom_range(10, 15)), 4'($urandom()), rnd40());
          else if ($urandom_range(1))
            put_write(ch, 4'($urandom_range(SEL_CAL_X, SEL_LIN_Y)),
                      4'($urandom_range(NPT, 15)), rnd40());
          else
            put_write(ch, 4'($urandom_range(SEL_DB_LOW, SEL_DB_VALUE)),
                      4'($urandom_range(NDB, 15)), rnd40());
        end
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int ch = 0; ch < NCH; ch++) begin
      put_axis(ch, SEL_CAL_X, 0, 0);
      for (int i = 0; i < NPT; i++) begin
        put_write(ch, SEL_CAL_X, 4'(i), longint'(i) * 64'h1C000000);
        put_write(ch, SEL_CAL_Y, 4'(i), longint'(i) * 1000000 * (ch + 1) - 3000000);
      end
      put_axis(ch, SEL_TEMP_X, -64'sd1000000000, 32'h0FFFFFFF);
      put_axis(ch, SEL_LIN_X, -64'sd4000000000, 32'h3FFFFFFF);
      for (int i = 0; i < NPT; i++) begin
        put_write(ch, SEL_TEMP_Y, 4'(i), 5000 * i - 20000);
        put_write(ch, SEL_LIN_Y, 4'(i), 300 - 70 * i);
      end
      for (int j = 0; j < NDB; j++) begin
        put_write(ch, SEL_DB_LOW, 4'(j), 1000000 * j);
        put_write(ch, SEL_DB_HIGH, 4'(j), 1000000 * j + 50000);
        put_write(ch, SEL_DB_VALUE, 4'(j), -7 * j);
      end
    end
    // clamp low, clamp high, exact point, interior
    put_conv(0, 16'h0000, 0);
    put_conv(0, 16'hFFFF, 0);
    put_conv(0, 16'(16'h1C00 * 3), 0);
    put_conv(0, 16'd12345, 0);
    // saturate upwards
    put_write(1, SEL_CAL_Y, 4'(NPT - 1), MAXV);
    put_write(1, SEL_TEMP_Y, 4'(NPT - 1), MAXV);
    put_write(1, SEL_SWITCHES, 0, 1);
    put_conv(1, 16'hFFFF, MAXV);
    // saturate downwards
    put_write(2, SEL_CAL_Y, 0, MINV);
    put_write(2, SEL_TEMP_Y, 0, MINV);
    put_write(2, SEL_SWITCHES, 15, 3);
    put_conv(2, 16'h0000, MINV);
    // all switches, deadband covering everything
    put_write(3, SEL_SWITCHES, 9, MINV + 7);
    put_write(3, SEL_DB_LOW, 0, MINV);
    put_write(3, SEL_DB_HIGH, 0, MAXV);
    put_write(3, SEL_DB_VALUE, 0, MAXV);
    put_conv(3, 16'd40000, 12345);
    put_write(3, SEL_SWITCHES, 0, 6);
    put_write(3, SEL_DB_LOW, 0, MAXV);
    put_conv(3, 16'd500, MINV);
    // ignored writes
    put_write(0, SEL_UNUSED, 15, MAXV);
    put_write(0, SEL_DB_VALUE, 9, MINV);
    put_write(0, SEL_CAL_X, 12, 0);
    put_conv(0, 16'd7, 0);
    settle();
    random_run(460);
    settle();
    send_idle = 86;
    recv_idle = 22;
    random_run(420);
    settle();
    send_idle = 0;
    recv_idle = 0;
    @(posedge clk);
    hold_go <= 1'b1;
    random_run(420);
    settle();
    repeat (400) @(posedge clk);
    $display("covered %0d checked readings, %0d table and switch writes, %0d ignored writes",
             n_checked, n_writes, n_ignored);
    if (errors == 0 && readings_q.size() == 0) begin
      $display("sensor_calibration_linearizer_tb: PASS");
    end else begin
      $display("sensor_calibration_linearizer_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("sensor_calibration_linearizer_tb: FAIL");
    $finish;
  end

endmodule
